>>> src/sfir_pkg.sv
// Shared constants and types for the symmetric Q15 FIR filter.
package sfir_pkg;

    // Sample and coefficient formats.
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    // A pre-added pair is one bit wider than a sample.
    localparam int PROD_W   = SAMPLE_W + 1 + COEF_W;

    // Configuration bank: packed coefficient words.
    localparam int COEF_WORDS = 8;
    localparam int COEF_LANES = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Default filter shape.
    localparam int TAPS_DEF      = 63;
    localparam int OUT_SHIFT_DEF = 15;

    // Saturation limits of the output.
    localparam int MAX_POS = 32767;
    localparam int MIN_NEG = -32768;

    // Counter widths.
    localparam int CNT_W = 16;
    localparam int SEG_W = 32;

    // Control that travels beside the data through the pipeline.
    typedef struct packed {
        logic valid;
        logic start;
        logic user;
        logic last;
        logic id;
        logic dest;
    } ctrl_t;

endpackage

>>> src/sfir_delay_cell.sv
// One cell of the sample history line.
module sfir_delay_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic                                clear,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] d,
    output logic signed [sfir_pkg::SAMPLE_W-1:0] q
);

    logic signed [sfir_pkg::SAMPLE_W-1:0] hist_reg;

    // Take the neighbour's sample on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (shift)
        begin
            hist_reg <= d;
        end
    end

    // A history clear makes the stored sample read as zero for this beat.
    assign q = clear ? '0 : hist_reg;

endmodule

>>> src/sfir_mac_cell.sv
// Pre-adder and multiplier for one mirrored tap pair, with a registered product.
module sfir_mac_cell (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] a,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0] b,
    input  logic signed [sfir_pkg::COEF_W-1:0]   coef,
    output logic signed [sfir_pkg::PROD_W-1:0]   prod
);

    logic signed [sfir_pkg::SAMPLE_W:0]  pair;
    logic signed [sfir_pkg::PROD_W-1:0]  prod_next;
    logic signed [sfir_pkg::PROD_W-1:0]  prod_reg;

    // Pre-add the mirrored samples, then one multiply.
    always_comb
    begin
        pair      = (sfir_pkg::SAMPLE_W + 1)'(a) + (sfir_pkg::SAMPLE_W + 1)'(b);
        prod_next = sfir_pkg::PROD_W'(pair) * sfir_pkg::PROD_W'(coef);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> src/sfir_add_tree.sv
// Registered binary adder tree that sums the tap products, with its control line.
module sfir_add_tree #(
    parameter int DEPTH = 5,
    parameter int ACC_W = 38
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic signed [ACC_W-1:0] leaf [2**DEPTH],
    input  sfir_pkg::ctrl_t         ctrl_in,
    output logic signed [ACC_W-1:0] sum,
    output sfir_pkg::ctrl_t         ctrl_out
);

    localparam int NLEAF = 2**DEPTH;

    // Heap layout: node i adds nodes 2i and 2i+1; leaves sit above NLEAF-1.
    logic signed [ACC_W-1:0] node_reg [1:NLEAF-1];
    sfir_pkg::ctrl_t         ctrl_reg [DEPTH];

    for (genvar i = 1; i < NLEAF; i++)
    begin : gen_node
        logic signed [ACC_W-1:0] left;
        logic signed [ACC_W-1:0] right;

        if (2 * i >= NLEAF)
        begin : gen_from_leaf
            assign left  = leaf[2 * i - NLEAF];
            assign right = leaf[2 * i + 1 - NLEAF];
        end
        else
        begin : gen_from_node
            assign left  = node_reg[2 * i];
            assign right = node_reg[2 * i + 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                node_reg[i] <= left + right;
            end
        end
    end

    // Control follows the data one level per beat.
    for (genvar d = 0; d < DEPTH; d++)
    begin : gen_ctrl
        sfir_pkg::ctrl_t ctrl_d;

        if (d == 0)
        begin : gen_first
            assign ctrl_d = ctrl_in;
        end
        else
        begin : gen_next
            assign ctrl_d = ctrl_reg[d - 1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[d] <= '0;
            end
            else if (en)
            begin
                ctrl_reg[d] <= ctrl_d;
            end
        end
    end

    assign sum      = node_reg[1];
    assign ctrl_out = ctrl_reg[DEPTH - 1];

endmodule

>>> src/symmetric_fir_q15_saturating.sv
// An accepted sample passes the product registers, the adder tree and the output register.
// Throughput: one sample per clock; the pipeline stalls as a whole only while a result waits.
// Each level of the adder tree, which sums the (TAPS+1)/2 tap products, is registered.
// Reset clears the history line, the coefficient registers, the clip, sample and segment
// counters and all valid flags; no clearing pass is needed, so samples are taken at once.
module symmetric_fir_q15_saturating #(
    parameter int TAPS      = sfir_pkg::TAPS_DEF,
    parameter int OUT_SHIFT = sfir_pkg::OUT_SHIFT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sfir_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  segment_start,
    input  logic                                  clear_history,
    input  logic                                  segment_end,
    input  logic                                  side_user,
    input  logic                                  side_last,
    input  logic                                  side_id,
    input  logic                                  side_dest,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sfir_pkg::SAMPLE_W-1:0]  filtered,
    output logic                                  saturated,
    output logic                                  user_out,
    output logic                                  last_out,
    output logic                                  id_out,
    output logic                                  dest_out,
    output logic [sfir_pkg::CNT_W-1:0]            saturation_total,
    output logic [sfir_pkg::CNT_W-1:0]            sample_total,
    output logic [sfir_pkg::SEG_W-1:0]            segment_number
);

    localparam int HIST  = TAPS - 1;
    localparam int PAIRS = (TAPS - 1) / 2;
    localparam int NPROD = PAIRS + 1;
    localparam int DEPTH = (NPROD > 1) ? $clog2(NPROD) : 1;
    localparam int NLEAF = 2**DEPTH;
    localparam int ACC_W = sfir_pkg::PROD_W + DEPTH;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(sfir_pkg::MAX_POS);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(sfir_pkg::MIN_NEG);

    // Coefficient bank.
    logic [sfir_pkg::CFG_DATA_W-1:0] coef_reg [sfir_pkg::COEF_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < sfir_pkg::COEF_WORDS; w++)
            begin
                coef_reg[w] <= '0;
            end
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Handshake: the whole pipeline moves whenever the output register can be refilled.
    logic out_valid_reg;
    logic en;
    logic accept;
    logic clr;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;
    assign clr      = segment_start && clear_history;

    // History line: win[0] is the new sample, win[k] the k-th older one.
    logic signed [sfir_pkg::SAMPLE_W-1:0] win [HIST + 1];

    assign win[0] = sample;

    for (genvar k = 0; k < HIST; k++)
    begin : gen_hist
        sfir_delay_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .clear (clr),
            .d     (win[k]),
            .q     (win[k + 1])
        );
    end

    // Tap cells: mirrored pairs, then the centre tap with a zero partner.
    logic signed [ACC_W-1:0] leaf [NLEAF];

    for (genvar j = 0; j < NLEAF; j++)
    begin : gen_tap
        if (j < NPROD)
        begin : gen_mac
            localparam int CW = j / sfir_pkg::COEF_LANES;
            localparam int CL = j % sfir_pkg::COEF_LANES;

            logic signed [sfir_pkg::SAMPLE_W-1:0] mirror;
            logic signed [sfir_pkg::COEF_W-1:0]   coef;
            logic signed [sfir_pkg::PROD_W-1:0]   prod;

            if (j < PAIRS)
            begin : gen_pair
                assign mirror = win[TAPS - 1 - j];
            end
            else
            begin : gen_centre
                assign mirror = '0;
            end

            assign coef = coef_reg[CW][CL * sfir_pkg::COEF_W +: sfir_pkg::COEF_W];

            sfir_mac_cell u_mac (
                .clk  (clk),
                .en   (en),
                .a    (win[j]),
                .b    (mirror),
                .coef (coef),
                .prod (prod)
            );

            assign leaf[j] = ACC_W'(prod);
        end
        else
        begin : gen_pad
            assign leaf[j] = '0;
        end
    end

    // Control beside the product registers.
    sfir_pkg::ctrl_t ctrl_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_m_reg <= '0;
        end
        else if (en)
        begin
            ctrl_m_reg.valid <= accept;
            ctrl_m_reg.start <= segment_start;
            ctrl_m_reg.user  <= side_user;
            ctrl_m_reg.last  <= side_last;
            ctrl_m_reg.id    <= side_id;
            ctrl_m_reg.dest  <= side_dest;
        end
    end

    // Sum of all tap products.
    logic signed [ACC_W-1:0] acc;
    sfir_pkg::ctrl_t         ctrl_t_out;

    sfir_add_tree #(
        .DEPTH (DEPTH),
        .ACC_W (ACC_W)
    ) u_tree (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .leaf     (leaf),
        .ctrl_in  (ctrl_m_reg),
        .sum      (acc),
        .ctrl_out (ctrl_t_out)
    );

    // Scale by an arithmetic shift (floor), then clip to the sample range.
    logic signed [ACC_W-1:0]             scaled;
    logic                                sat_next;
    logic signed [sfir_pkg::SAMPLE_W-1:0] filt_next;

    always_comb
    begin
        scaled = acc >>> OUT_SHIFT;
        if (scaled > SAT_HI)
        begin
            sat_next  = 1'b1;
            filt_next = SAT_HI[sfir_pkg::SAMPLE_W-1:0];
        end
        else if (scaled < SAT_LO)
        begin
            sat_next  = 1'b1;
            filt_next = SAT_LO[sfir_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            sat_next  = 1'b0;
            filt_next = scaled[sfir_pkg::SAMPLE_W-1:0];
        end
    end

    // Per-segment counters, updated as each result enters the output register.
    logic [sfir_pkg::CNT_W-1:0] clip_reg;
    logic [sfir_pkg::CNT_W-1:0] clip_next;
    logic [sfir_pkg::CNT_W-1:0] samp_reg;
    logic [sfir_pkg::CNT_W-1:0] samp_next;
    logic [sfir_pkg::SEG_W-1:0] seg_reg;
    logic [sfir_pkg::SEG_W-1:0] seg_next;

    always_comb
    begin
        seg_next  = seg_reg + sfir_pkg::SEG_W'(ctrl_t_out.start);
        samp_next = (ctrl_t_out.start ? '0 : samp_reg) + sfir_pkg::CNT_W'(1);
        clip_next = (ctrl_t_out.start ? '0 : clip_reg) + sfir_pkg::CNT_W'(sat_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= '0;
            samp_reg <= '0;
            seg_reg  <= '0;
        end
        else if (en && ctrl_t_out.valid)
        begin
            clip_reg <= clip_next;
            samp_reg <= samp_next;
            seg_reg  <= seg_next;
        end
    end

    // Output register.
    logic signed [sfir_pkg::SAMPLE_W-1:0] filt_reg;
    logic                                 sat_reg;
    logic                                 user_reg;
    logic                                 last_reg;
    logic                                 id_reg;
    logic                                 dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctrl_t_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctrl_t_out.valid)
        begin
            filt_reg <= filt_next;
            sat_reg  <= sat_next;
            user_reg <= ctrl_t_out.user;
            last_reg <= ctrl_t_out.last;
            id_reg   <= ctrl_t_out.id;
            dest_reg <= ctrl_t_out.dest;
        end
    end

    // The end-of-segment mark carries no state; the counters restart on the next start.
    logic unused_end;
    assign unused_end = segment_end;

    assign out_valid        = out_valid_reg;
    assign filtered         = filt_reg;
    assign saturated        = sat_reg;
    assign user_out         = user_reg;
    assign last_out         = last_reg;
    assign id_out           = id_reg;
    assign dest_out         = dest_reg;
    assign saturation_total = clip_reg;
    assign sample_total     = samp_reg;
    assign segment_number   = seg_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the symmetric Q15 FIR filter: directed table, random segments, stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Package constants in local form.
    localparam int SAMPLE_W   = sfir_pkg::SAMPLE_W;
    localparam int COEF_W     = sfir_pkg::COEF_W;
    localparam int COEF_WORDS = sfir_pkg::COEF_WORDS;
    localparam int COEF_LANES = sfir_pkg::COEF_LANES;
    localparam int CFG_DATA_W = sfir_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W  = sfir_pkg::CFG_IDX_W;
    localparam int MAX_POS    = sfir_pkg::MAX_POS;
    localparam int MIN_NEG    = sfir_pkg::MIN_NEG;
    localparam int CNT_W      = sfir_pkg::CNT_W;
    localparam int SEG_W      = sfir_pkg::SEG_W;

    localparam int TAPS          = sfir_pkg::TAPS_DEF;
    localparam int OUT_SHIFT     = sfir_pkg::OUT_SHIFT_DEF;
    localparam int HIST_LEN      = TAPS - 1;
    localparam int PIPE_LATENCY  = $clog2((TAPS + 1) / 2) + 1;
    localparam int MAX_WAIT      = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 9;
    localparam int CYCLE_LIMIT   = 500000;

    // Coefficient word patterns used by the directed table.
    localparam logic [CFG_DATA_W-1:0] W_ZERO   = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] W_H0_NEG = 64'h0000_0000_0000_8000;
    localparam logic [CFG_DATA_W-1:0] W_ALL_NEG = 64'h8000_8000_8000_8000;
    localparam logic [CFG_DATA_W-1:0] W_ALL_POS = 64'h7fff_7fff_7fff_7fff;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_WORD_0, COEF_WORD_1, COEF_WORD_2, COEF_WORD_3,
        COEF_WORD_4, COEF_WORD_5, COEF_WORD_6, COEF_WORD_7
    } coef_reg_e;

    typedef enum int {COEF_FULL, COEF_SMALL, COEF_EXTREME, COEF_SPARSE} coef_style_e;

    // One input beat; side holds {user, last, id, dest}.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       segment_start;
        logic                       clear_history;
        logic                       segment_end;
        logic [3:0]                 side;
    } sample_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       saturated;
        logic                       user_out;
        logic                       last_out;
        logic                       id_out;
        logic                       dest_out;
        logic [CNT_W-1:0]           saturation_total;
        logic [CNT_W-1:0]           sample_total;
        logic [SEG_W-1:0]           segment_number;
    } fir_result_t;

    // A directed row may reload the coefficient bank (word 0 and the other seven) first.
    typedef struct packed {
        logic                       load;
        logic [CFG_DATA_W-1:0]      word0;
        logic [CFG_DATA_W-1:0]      other_words;
        sample_beat_t               beat;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want_filtered;
        logic                       want_saturated;
    } directed_row_t;

    localparam directed_row_t DIRECTED [0:21] = '{
        // Zero coefficients after reset, before any segment start.
        '{1'b0, W_ZERO, W_ZERO, '{16'sh7fff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b1, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh8000, 1'b0, 1'b1, 1'b0, 4'b1111}, 1'b1, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh0000, 1'b0, 1'b0, 1'b1, 4'b0000}, 1'b1, 16'sh0000, 1'b0},
        // Only h0 = -1.0: the output is the negated newest sample while w62 is zero.
        '{1'b1, W_H0_NEG, W_ZERO, '{16'sh8000, 1'b1, 1'b1, 1'b0, 4'b0000}, 1'b1, 16'sh7fff, 1'b1},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh7fff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b1, 16'sh8001, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'shffff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b1, 16'sh0001, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh0001, 1'b0, 1'b0, 1'b0, 4'b1010}, 1'b1, 16'shffff, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh0000, 1'b0, 1'b0, 1'b1, 4'b0000}, 1'b1, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh3039, 1'b1, 1'b0, 1'b0, 4'b0101}, 1'b1, 16'shcfc7, 1'b0},
        // Every coefficient -1.0: the sum runs into the negative limit and back out of it.
        '{1'b1, W_ALL_NEG, W_ALL_NEG, '{16'sh7fff, 1'b1, 1'b1, 1'b0, 4'b0000},
          1'b1, 16'sh8001, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh7fff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh7fff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh7fff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh8000, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh8000, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh8000, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh8000, 1'b0, 1'b0, 1'b1, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        // Every coefficient at the positive limit.
        '{1'b1, W_ALL_POS, W_ALL_POS, '{16'sh7fff, 1'b1, 1'b1, 1'b0, 4'b1111},
          1'b1, 16'sh7ffe, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh7fff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh7fff, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh8000, 1'b0, 1'b0, 1'b0, 4'b0000}, 1'b0, 16'sh0000, 1'b0},
        '{1'b0, W_ZERO, W_ZERO, '{16'sh8000, 1'b1, 1'b0, 1'b1, 4'b0100}, 1'b0, 16'sh0000, 1'b0}
    };

    // Block ports.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       segment_start = 1'b0;
    logic                       clear_history = 1'b0;
    logic                       segment_end = 1'b0;
    logic                       side_user = 1'b0;
    logic                       side_last = 1'b0;
    logic                       side_id = 1'b0;
    logic                       side_dest = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
    logic                       user_out;
    logic                       last_out;
    logic                       id_out;
    logic                       dest_out;
    logic [CNT_W-1:0]           saturation_total;
    logic [CNT_W-1:0]           sample_total;
    logic [SEG_W-1:0]           segment_number;

    // Filter state as the testbench sees it.
    logic [CFG_DATA_W-1:0]      coef_words [COEF_WORDS] = '{default: '0};
    logic [CFG_DATA_W-1:0]      next_coefs [COEF_WORDS] = '{default: '0};
    logic signed [SAMPLE_W-1:0] hist [HIST_LEN] = '{default: '0};
    logic [CNT_W-1:0]           clip_count = '0;
    logic [CNT_W-1:0]           sample_count = '0;
    logic [SEG_W-1:0]           segment_count = '0;

    fir_result_t expected_results [$];

    int  mismatch_count = 0;
    int  results_checked = 0;
    int  items_sent = 0;
    int  segments_started = 0;
    int  clips_predicted = 0;
    int  bank_loads = 0;
    int  input_stall_cycles = 0;
    int  cycle_count = 0;
    int  seg_left = 0;
    int  in_gap_max = MAX_WAIT;
    int  out_gap_max = MAX_WAIT;
    logic hold_pending = 1'b0;

    symmetric_fir_q15_saturating DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .segment_start    (segment_start),
        .clear_history    (clear_history),
        .segment_end      (segment_end),
        .side_user        (side_user),
        .side_last        (side_last),
        .side_id          (side_id),
        .side_dest        (side_dest),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .filtered         (filtered),
        .saturated        (saturated),
        .user_out         (user_out),
        .last_out         (last_out),
        .id_out           (id_out),
        .dest_out         (dest_out),
        .saturation_total (saturation_total),
        .sample_total     (sample_total),
        .segment_number   (segment_number)
    );

    always #6 clk = ~clk;

    // Run limit in clock cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Cycles in which the block refused an offered beat.
    always @(negedge clk)
    begin
        if (in_valid && in_ready === 1'b0)
            input_stall_cycles <= input_stall_cycles + 1;
    end

    function automatic int draw_wait(input int max_wait);
        if (max_wait == 0 || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, max_wait);
    endfunction

    function automatic logic signed [COEF_W-1:0] tap_coef(input int k);
        return coef_words[k / COEF_LANES][(k % COEF_LANES) * COEF_W +: COEF_W];
    endfunction

    // Advances the filter state by one sample and returns the result it produces.
    function automatic fir_result_t predict_fir(input sample_beat_t b);
        logic signed [SAMPLE_W-1:0] win [TAPS];
        longint acc;
        longint quot;
        fir_result_t r;
        if (b.segment_start)
        begin
            if (b.clear_history)
                foreach (hist[i]) hist[i] = '0;
            clip_count = '0;
            sample_count = '0;
            segment_count = segment_count + 1'b1;
        end
        win[0] = b.sample;
        for (int k = 1; k < TAPS; k++)
            win[k] = hist[k - 1];

        // Mirrored taps share a coefficient; the centre tap stands alone.
        acc = 0;
        for (int k = 0; k < (TAPS - 1) / 2; k++)
            acc += longint'(tap_coef(k)) * (longint'(win[k]) + longint'(win[TAPS - 1 - k]));
        acc += longint'(tap_coef(TAPS / 2)) * longint'(win[TAPS / 2]);
        quot = acc >>> OUT_SHIFT;

        r.saturated = 1'b1;
        if (quot > MAX_POS)
            r.filtered = SAMPLE_W'(MAX_POS);
        else if (quot < MIN_NEG)
            r.filtered = SAMPLE_W'(MIN_NEG);
        else
        begin
            r.filtered = SAMPLE_W'(quot);
            r.saturated = 1'b0;
        end

        for (int k = HIST_LEN - 1; k > 0; k--)
            hist[k] = hist[k - 1];
        hist[0] = b.sample;
        sample_count = sample_count + 1'b1;
        if (r.saturated)
            clip_count = clip_count + 1'b1;

        {r.user_out, r.last_out, r.id_out, r.dest_out} = b.side;
        r.saturation_total = clip_count;
        r.sample_total = sample_count;
        r.segment_number = segment_count;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coef_word(input coef_style_e style);
        logic [CFG_DATA_W-1:0] w;
        logic [COEF_W-1:0] lane;
        w = '0;
        for (int i = 0; i < COEF_LANES; i++)
        begin
            case (style)
                COEF_FULL:  lane = COEF_W'($urandom);
                COEF_SMALL: lane = COEF_W'($urandom_range(0, 2047) - 1024);
                COEF_EXTREME:
                begin
                    case ($urandom_range(0, 2))
                        0:       lane = 16'h7fff;
                        1:       lane = 16'h8000;
                        default: lane = 16'h0000;
                    endcase
                end
                default:    lane = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom) : '0;
            endcase
            w[i * COEF_W +: COEF_W] = lane;
        end
        return w;
    endfunction

    // Mostly well-formed segments of random length, with stray clears and flipped ends.
    function automatic sample_beat_t random_beat();
        sample_beat_t b;
        b = '0;
        case ($urandom_range(0, 3))
            1:       b.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2:       b.sample = SAMPLE_W'($urandom_range(0, 127) - 64);
            default: b.sample = SAMPLE_W'($urandom);
        endcase
        b.side = 4'($urandom);
        if (seg_left == 0 && $urandom_range(0, 7) != 0)
        begin
            b.segment_start = 1'b1;
            b.clear_history = 1'($urandom_range(0, 1));
            seg_left = $urandom_range(1, 40);
        end
        else if ($urandom_range(0, 7) == 0)
            b.clear_history = 1'b1;
        if (seg_left > 0)
        begin
            seg_left--;
            b.segment_end = (seg_left == 0);
        end
        if ($urandom_range(0, 15) == 0)
            b.segment_end = ~b.segment_end;
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      results_checked, field, got, want));
    endtask

    // Offers one beat after a random gap and records its expected result once taken.
    task automatic send_sample(input sample_beat_t b, input logic typed,
                               input logic signed [SAMPLE_W-1:0] want_filtered,
                               input logic want_saturated);
        int gap;
        fir_result_t r;
        gap = draw_wait(in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= b.sample;
        segment_start <= b.segment_start;
        clear_history <= b.clear_history;
        segment_end <= b.segment_end;
        {side_user, side_last, side_id, side_dest} <= b.side;
        do @(negedge clk); while (in_ready !== 1'b1);
        @(posedge clk);
        r = predict_fir(b);
        if (typed)
        begin
            r.filtered = want_filtered;
            r.saturated = want_saturated;
        end
        expected_results.push_back(r);
        items_sent++;
        if (b.segment_start)
            segments_started++;
        if (r.saturated)
            clips_predicted++;
    endtask

    task automatic send_random_samples(input int count);
        for (int i = 0; i < count; i++)
            send_sample(random_beat(), 1'b0, '0, 1'b0);
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Writes all coefficient words from next_coefs, one per cycle.
    task automatic load_coef_bank();
        for (int w = 0; w < COEF_WORDS; w++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= coef_reg_e'(w);
            cfg_data <= next_coefs[w];
            coef_words[w] = next_coefs[w];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        bank_loads++;
    endtask

    // Result side: random stalls, one long hold on request, and the check of every beat.
    initial
    begin : result_sink
        fir_result_t want;
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                stall = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            else
                stall = draw_wait(out_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (out_valid !== 1'b1);
            if (expected_results.size() == 0)
                report_mismatch("result beat arrived with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                check_field("filtered", 32'(filtered), 32'(want.filtered));
                check_field("saturated", 32'(saturated), 32'(want.saturated));
                check_field("user_out", 32'(user_out), 32'(want.user_out));
                check_field("last_out", 32'(last_out), 32'(want.last_out));
                check_field("id_out", 32'(id_out), 32'(want.id_out));
                check_field("dest_out", 32'(dest_out), 32'(want.dest_out));
                check_field("saturation_total", 32'(saturation_total),
                            32'(want.saturation_total));
                check_field("sample_total", 32'(sample_total), 32'(want.sample_total));
                check_field("segment_number", segment_number, want.segment_number);
            end
            results_checked++;
            @(posedge clk);
        end
    end

    // Sample side: directed table, then random phases.
    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; rows with a load flag first reprogram the bank while idle.
        foreach (DIRECTED[r])
        begin
            if (DIRECTED[r].load)
            begin
                drain_results();
                next_coefs[COEF_WORD_0] = DIRECTED[r].word0;
                for (int w = 1; w < COEF_WORDS; w++)
                    next_coefs[w] = DIRECTED[r].other_words;
                load_coef_bank();
            end
            send_sample(DIRECTED[r].beat, DIRECTED[r].typed, DIRECTED[r].want_filtered,
                        DIRECTED[r].want_saturated);
        end

        // Random phases, each with a fresh coefficient bank and its own idling pattern.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            for (int w = 0; w < COEF_WORDS; w++)
                next_coefs[w] = random_coef_word(coef_style_e'(p % 4));
            load_coef_bank();
            in_gap_max = (p % 3 == 2) ? 0 : MAX_WAIT;
            out_gap_max = (p % 3 == 1) ? 0 : MAX_WAIT;
            if (p == 3)
            begin
                // The sink holds off while beats keep coming, so the pipeline backs up.
                hold_pending = 1'b1;
                in_gap_max = 0;
                send_random_samples(60);
                in_gap_max = MAX_WAIT;
                send_random_samples(PHASE_ITEMS - 60);
            end
            else if (p == 5)
            begin
                // The source pauses mid-phase until the pipeline has emptied.
                send_random_samples(PHASE_ITEMS / 2);
                drain_results();
                send_random_samples(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                send_random_samples(PHASE_ITEMS);
        end

        drain_results();
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        $display("Checked %0d results from %0d samples, %0d segment starts and %0d bank loads.",
                 results_checked, items_sent, segments_started, bank_loads);
        $display("%0d clipped results expected; input back-pressured for %0d cycles.",
                 clips_predicted, input_stall_cycles);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> symmetric_fir_q15_saturating.f
src/sfir_pkg.sv
src/sfir_delay_cell.sv
src/sfir_mac_cell.sv
src/sfir_add_tree.sv
src/symmetric_fir_q15_saturating.sv
tb/testbench.sv
